FILE: design/battery_charge_state_tracker_macros.svh
// assertion macros for the battery charge state tracker
`ifndef BATTERY_CHARGE_STATE_TRACKER_MACROS_SVH
`define BATTERY_CHARGE_STATE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS
`define BCST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bcst assertion failed");
`define BCST_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("bcst assertion failed");
`else
`define BCST_ASSERT(name, prop)
`define BCST_ASSERT_ALWAYS(name, prop)
`endif

`endif

FILE: design/bcst_pkg.sv
// types, constants and helpers of the battery charge state tracker
package bcst_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_IDX_CHARGE_LIMIT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_DISCHARGE_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_FULL_TAPER      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_IDX_FULL_LEVEL      = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_IDX_FULL_SETTLE     = 3'd4;

  localparam logic [14:0] CHARGE_LIMIT_RST    = 15'd50;
  localparam logic [14:0] DISCHARGE_LIMIT_RST = 15'd50;
  localparam logic [14:0] FULL_TAPER_RST      = 15'd100;
  localparam logic [6:0]  FULL_LEVEL_RST      = 7'd95;
  localparam logic [31:0] FULL_SETTLE_RST     = 32'd30000;

  // reported state codes
  localparam logic [2:0] STATE_UNKNOWN     = 3'd0;
  localparam logic [2:0] STATE_ABSENT      = 3'd1;
  localparam logic [2:0] STATE_DISCHARGING = 3'd2;
  localparam logic [2:0] STATE_CHARGING    = 3'd3;
  localparam logic [2:0] STATE_FULL        = 3'd4;

  // validity bit positions
  localparam int unsigned VB_SOC    = 0;
  localparam int unsigned VB_VOLT   = 1;
  localparam int unsigned VB_CURR   = 2;
  localparam int unsigned VB_HEALTH = 3;
  localparam int unsigned VB_CYCLES = 4;
  localparam int unsigned VB_EMPTY  = 5;
  localparam int unsigned VB_FULLT  = 6;

  typedef enum logic [4:0] {
    MODE_UNKNOWN     = 5'b00001,
    MODE_ABSENT      = 5'b00010,
    MODE_DISCHARGING = 5'b00100,
    MODE_CHARGING    = 5'b01000,
    MODE_FULL        = 5'b10000
  } mode_e;

  typedef struct packed {
    logic [14:0] charge_limit_ma;
    logic [14:0] discharge_limit_ma;
    logic [14:0] full_taper_ma;
    logic [6:0]  full_charge_level;
    logic [31:0] full_settle_ms;
  } cfg_t;

  typedef struct packed {
    logic               battery_inserted;
    logic               charger_active;
    logic [6:0]         validity_bits;
    logic [7:0]         gauge_soc;
    logic [15:0]        gauge_voltage_mv;
    logic signed [15:0] gauge_current_ma;
    logic [7:0]         gauge_health;
    logic [15:0]        gauge_cycles;
    logic [31:0]        gauge_empty_time_s;
    logic [31:0]        gauge_full_time_s;
    logic [31:0]        time_now_ms;
  } item_t;

  typedef struct packed {
    logic [2:0]         battery_state;
    logic               is_present;
    logic               report_trusted;
    logic [7:0]         reported_soc;
    logic [15:0]        reported_voltage_mv;
    logic signed [15:0] reported_current_ma;
    logic [7:0]         reported_health;
    logic [15:0]        reported_cycles;
    logic [31:0]        reported_empty_time_s;
    logic [31:0]        reported_full_time_s;
    logic               full_settled;
  } res_t;

  typedef struct packed {
    mode_e       mode;
    logic        pending;
    logic [31:0] start_ms;
  } state_t;

  function automatic logic [2:0] mode_code(mode_e mode);
    logic [2:0] code;
    unique case (mode)
      MODE_UNKNOWN:     code = STATE_UNKNOWN;
      MODE_ABSENT:      code = STATE_ABSENT;
      MODE_DISCHARGING: code = STATE_DISCHARGING;
      MODE_CHARGING:    code = STATE_CHARGING;
      MODE_FULL:        code = STATE_FULL;
      default:          code = STATE_UNKNOWN;
    endcase
    return code;
  endfunction

endpackage

FILE: design/bcst_req_if.sv
// request channel carrying one telemetry snapshot
interface bcst_req_if;
  logic               valid;
  logic               ready;
  logic               battery_inserted;
  logic               charger_active;
  logic [6:0]         validity_bits;
  logic [7:0]         gauge_soc;
  logic [15:0]        gauge_voltage_mv;
  logic signed [15:0] gauge_current_ma;
  logic [7:0]         gauge_health;
  logic [15:0]        gauge_cycles;
  logic [31:0]        gauge_empty_time_s;
  logic [31:0]        gauge_full_time_s;
  logic [31:0]        time_now_ms;

  modport source (
    output valid, battery_inserted, charger_active, validity_bits, gauge_soc,
           gauge_voltage_mv, gauge_current_ma, gauge_health, gauge_cycles,
           gauge_empty_time_s, gauge_full_time_s, time_now_ms,
    input  ready
  );

  modport sink (
    input  valid, battery_inserted, charger_active, validity_bits, gauge_soc,
           gauge_voltage_mv, gauge_current_ma, gauge_health, gauge_cycles,
           gauge_empty_time_s, gauge_full_time_s, time_now_ms,
    output ready
  );
endinterface

FILE: design/bcst_res_if.sv
// result channel carrying one battery report
interface bcst_res_if;
  logic               valid;
  logic               ready;
  logic [2:0]         battery_state;
  logic               is_present;
  logic               report_trusted;
  logic [7:0]         reported_soc;
  logic [15:0]        reported_voltage_mv;
  logic signed [15:0] reported_current_ma;
  logic [7:0]         reported_health;
  logic [15:0]        reported_cycles;
  logic [31:0]        reported_empty_time_s;
  logic [31:0]        reported_full_time_s;
  logic               full_settled;

  modport source (
    output valid, battery_state, is_present, report_trusted, reported_soc,
           reported_voltage_mv, reported_current_ma, reported_health,
           reported_cycles, reported_empty_time_s, reported_full_time_s,
           full_settled,
    input  ready
  );

  modport sink (
    input  valid, battery_state, is_present, report_trusted, reported_soc,
           reported_voltage_mv, reported_current_ma, reported_health,
           reported_cycles, reported_empty_time_s, reported_full_time_s,
           full_settled,
    output ready
  );
endinterface

FILE: design/bcst_step.sv
// mode update and report build for one snapshot
module bcst_step (
  input  bcst_pkg::item_t  item_i,
  input  bcst_pkg::cfg_t   cfg_i,
  input  bcst_pkg::state_t state_i,
  output bcst_pkg::state_t state_o,
  output bcst_pkg::res_t   res_o
);

  logic               trusted;
  logic signed [15:0] cur;
  logic signed [16:0] cur_x;
  logic               ge_chg;
  logic               le_dis;
  logic               lt_taper;
  logic               soc_ok;
  logic               full_cond;
  logic [31:0]        elapsed;
  logic               settle_done;

  assign trusted = item_i.validity_bits[bcst_pkg::VB_SOC]
                 & item_i.validity_bits[bcst_pkg::VB_VOLT];
  assign cur     = item_i.validity_bits[bcst_pkg::VB_CURR] ?
                   $signed(item_i.gauge_current_ma) : 16'sd0;
  assign cur_x   = 17'(cur);

  assign ge_chg    = cur_x >= $signed({2'b00, cfg_i.charge_limit_ma});
  assign le_dis    = cur_x <= -$signed({2'b00, cfg_i.discharge_limit_ma});
  assign lt_taper  = cur_x <  $signed({2'b00, cfg_i.full_taper_ma});
  assign soc_ok    = item_i.gauge_soc >= {1'b0, cfg_i.full_charge_level};
  assign full_cond = item_i.charger_active & soc_ok & lt_taper;

  // a clock that went backwards counts as no elapsed time
  assign elapsed     = (item_i.time_now_ms >= state_i.start_ms) ?
                       item_i.time_now_ms - state_i.start_ms : 32'd0;
  assign settle_done = elapsed >= cfg_i.full_settle_ms;

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (!item_i.battery_inserted) begin
      state_o.mode    = bcst_pkg::MODE_ABSENT;
      state_o.pending = 1'b0;
      res_o.battery_state = bcst_pkg::STATE_ABSENT;
    end else if (!trusted) begin
      state_o.mode    = bcst_pkg::MODE_UNKNOWN;
      state_o.pending = 1'b0;
      res_o.battery_state = bcst_pkg::STATE_UNKNOWN;
      res_o.is_present    = 1'b1;
    end else begin
      res_o.is_present          = 1'b1;
      res_o.report_trusted      = 1'b1;
      res_o.reported_soc        = item_i.gauge_soc;
      res_o.reported_voltage_mv = item_i.gauge_voltage_mv;
      if (item_i.validity_bits[bcst_pkg::VB_CURR]) begin
        res_o.reported_current_ma = item_i.gauge_current_ma;
      end
      if (item_i.validity_bits[bcst_pkg::VB_HEALTH]) begin
        res_o.reported_health = item_i.gauge_health;
      end
      if (item_i.validity_bits[bcst_pkg::VB_CYCLES]) begin
        res_o.reported_cycles = item_i.gauge_cycles;
      end

      unique case (state_i.mode)
        bcst_pkg::MODE_UNKNOWN: begin
          priority if (ge_chg) begin
            state_o.mode = bcst_pkg::MODE_CHARGING;
          end else if (le_dis) begin
            state_o.mode = bcst_pkg::MODE_DISCHARGING;
          end else if (item_i.charger_active && soc_ok) begin
            state_o.mode = bcst_pkg::MODE_FULL;
          end else begin
            state_o.mode = bcst_pkg::MODE_DISCHARGING;
          end
        end
        bcst_pkg::MODE_ABSENT: begin
          state_o.mode = bcst_pkg::MODE_UNKNOWN;
        end
        bcst_pkg::MODE_DISCHARGING: begin
          priority if (ge_chg) begin
            state_o.mode    = bcst_pkg::MODE_CHARGING;
            state_o.pending = 1'b0;
          end else if (full_cond) begin
            state_o.mode     = bcst_pkg::MODE_FULL;
            state_o.pending  = 1'b1;
            state_o.start_ms = item_i.time_now_ms;
          end
        end
        bcst_pkg::MODE_CHARGING: begin
          priority if (le_dis) begin
            state_o.mode    = bcst_pkg::MODE_DISCHARGING;
            state_o.pending = 1'b0;
          end else if (full_cond) begin
            state_o.mode     = bcst_pkg::MODE_FULL;
            state_o.pending  = 1'b1;
            state_o.start_ms = item_i.time_now_ms;
          end
        end
        bcst_pkg::MODE_FULL: begin
          if (full_cond) begin
            if (state_i.pending && settle_done) begin
              state_o.pending = 1'b0;
            end
          end else begin
            state_o.mode    = ge_chg ? bcst_pkg::MODE_CHARGING
                                     : bcst_pkg::MODE_DISCHARGING;
            state_o.pending = 1'b0;
          end
        end
        default: begin
          state_o.mode = bcst_pkg::MODE_UNKNOWN;
        end
      endcase

      res_o.battery_state = bcst_pkg::mode_code(state_o.mode);
      if (state_o.mode == bcst_pkg::MODE_DISCHARGING &&
          item_i.validity_bits[bcst_pkg::VB_EMPTY]) begin
        res_o.reported_empty_time_s = item_i.gauge_empty_time_s;
      end
      if (state_o.mode == bcst_pkg::MODE_CHARGING &&
          item_i.validity_bits[bcst_pkg::VB_FULLT]) begin
        res_o.reported_full_time_s = item_i.gauge_full_time_s;
      end
      res_o.full_settled = (state_o.mode == bcst_pkg::MODE_FULL) && !state_o.pending;
    end
  end

endmodule

FILE: design/battery_charge_state_tracker.sv
// battery charge state tracker top level
// takes telemetry snapshots and returns one report per snapshot: the
// request lands in an input register, the mode update and report build run
// combinationally, and the report waits in a result register until the sink
// takes it. the mode, timer start and pending flag feed back from their
// registers through the same combinational step, so back to back requests
// are taken at one per clock as long as the result side keeps up.
// configuration writes apply on the clock edge where the write enable is high.
`include "battery_charge_state_tracker_macros.svh"

module battery_charge_state_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bcst_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bcst_pkg::CfgDataW-1:0]       cfg_wdata_i,
  bcst_req_if.sink                            req_i,
  bcst_res_if.source                          res_o
);

  bcst_pkg::cfg_t   cfg_q;
  bcst_pkg::item_t  req_d;
  bcst_pkg::item_t  req_q;
  logic             req_vld_q;
  bcst_pkg::state_t state_q;
  bcst_pkg::state_t state_d;
  bcst_pkg::res_t   res_d;
  bcst_pkg::res_t   res_q;
  logic             res_vld_q;
  logic             advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.charge_limit_ma    <= bcst_pkg::CHARGE_LIMIT_RST;
      cfg_q.discharge_limit_ma <= bcst_pkg::DISCHARGE_LIMIT_RST;
      cfg_q.full_taper_ma      <= bcst_pkg::FULL_TAPER_RST;
      cfg_q.full_charge_level  <= bcst_pkg::FULL_LEVEL_RST;
      cfg_q.full_settle_ms     <= bcst_pkg::FULL_SETTLE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcst_pkg::CFG_IDX_CHARGE_LIMIT:    cfg_q.charge_limit_ma    <= cfg_wdata_i[14:0];
        bcst_pkg::CFG_IDX_DISCHARGE_LIMIT: cfg_q.discharge_limit_ma <= cfg_wdata_i[14:0];
        bcst_pkg::CFG_IDX_FULL_TAPER:      cfg_q.full_taper_ma      <= cfg_wdata_i[14:0];
        bcst_pkg::CFG_IDX_FULL_LEVEL:      cfg_q.full_charge_level  <= cfg_wdata_i[6:0];
        bcst_pkg::CFG_IDX_FULL_SETTLE:     cfg_q.full_settle_ms     <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign advance     = !res_vld_q || res_o.ready;
  assign req_i.ready = !req_vld_q || advance;

  assign req_d.battery_inserted   = req_i.battery_inserted;
  assign req_d.charger_active     = req_i.charger_active;
  assign req_d.validity_bits      = req_i.validity_bits;
  assign req_d.gauge_soc          = req_i.gauge_soc;
  assign req_d.gauge_voltage_mv   = req_i.gauge_voltage_mv;
  assign req_d.gauge_current_ma   = req_i.gauge_current_ma;
  assign req_d.gauge_health       = req_i.gauge_health;
  assign req_d.gauge_cycles       = req_i.gauge_cycles;
  assign req_d.gauge_empty_time_s = req_i.gauge_empty_time_s;
  assign req_d.gauge_full_time_s  = req_i.gauge_full_time_s;
  assign req_d.time_now_ms        = req_i.time_now_ms;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      req_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_d;
    end
  end

  bcst_step u_step (
    .item_i  (req_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  // tracker state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= bcst_pkg::MODE_UNKNOWN;
      state_q.pending  <= 1'b0;
      state_q.start_ms <= 32'd0;
      res_vld_q        <= 1'b0;
    end else if (advance) begin
      res_vld_q <= req_vld_q;
      if (req_vld_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && req_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid                 = res_vld_q;
  assign res_o.battery_state         = res_q.battery_state;
  assign res_o.is_present            = res_q.is_present;
  assign res_o.report_trusted        = res_q.report_trusted;
  assign res_o.reported_soc          = res_q.reported_soc;
  assign res_o.reported_voltage_mv   = res_q.reported_voltage_mv;
  assign res_o.reported_current_ma   = res_q.reported_current_ma;
  assign res_o.reported_health       = res_q.reported_health;
  assign res_o.reported_cycles       = res_q.reported_cycles;
  assign res_o.reported_empty_time_s = res_q.reported_empty_time_s;
  assign res_o.reported_full_time_s  = res_q.reported_full_time_s;
  assign res_o.full_settled          = res_q.full_settled;

  // settle timer only runs in full mode
  `BCST_ASSERT(a_pending_only_full, state_q.pending |-> state_q.mode == bcst_pkg::MODE_FULL)
  // a settled report always carries the full state
  `BCST_ASSERT(a_settled_is_full, res_vld_q && res_q.full_settled |-> res_q.battery_state == bcst_pkg::STATE_FULL)
  // a report without a pack carries the absent state
  `BCST_ASSERT(a_absent_state, res_vld_q && !res_q.is_present |-> res_q.battery_state == bcst_pkg::STATE_ABSENT)
  // a held request is never dropped while the result side stalls
  `BCST_ASSERT(a_req_held, req_vld_q && !advance |=> req_vld_q)

endmodule

FILE: verif/battery_charge_state_tracker_checker.sv
// checker that predicts every battery report from the accepted requests and compares it
module battery_charge_state_tracker_checker
  import bcst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  bcst_req_if                 req,
  bcst_res_if                 res,
  output int                  fail_count_o,
  output int                  outstanding_o
);

  cfg_t        limits_q;
  logic [2:0]  mode_q;
  logic        settle_pending_q;
  logic [31:0] settle_start_q;
  res_t        pending_reports[$];
  int          mismatches;
  int          outstanding;

  assign fail_count_o  = mismatches;
  assign outstanding_o = outstanding;

  function automatic res_t track_battery(item_t snap);
    res_t        rep;
    int          cur;
    int          chg;
    int          dis;
    int          taper;
    logic        soc_ok;
    logic        full_cond;
    logic [31:0] elapsed;
    rep = '0;
    if (!snap.battery_inserted) begin
      mode_q = STATE_ABSENT;
      settle_pending_q = 1'b0;
      rep.battery_state = STATE_ABSENT;
      return rep;
    end
    rep.is_present = 1'b1;
    if (!(snap.validity_bits[VB_SOC] && snap.validity_bits[VB_VOLT])) begin
      mode_q = STATE_UNKNOWN;
      settle_pending_q = 1'b0;
      rep.battery_state = STATE_UNKNOWN;
      return rep;
    end
    rep.report_trusted = 1'b1;
    rep.reported_soc = snap.gauge_soc;
    rep.reported_voltage_mv = snap.gauge_voltage_mv;
    if (snap.validity_bits[VB_CURR]) rep.reported_current_ma = snap.gauge_current_ma;
    if (snap.validity_bits[VB_HEALTH]) rep.reported_health = snap.gauge_health;
    if (snap.validity_bits[VB_CYCLES]) rep.reported_cycles = snap.gauge_cycles;

    cur = snap.validity_bits[VB_CURR] ? int'(snap.gauge_current_ma) : 0;
    chg = int'(limits_q.charge_limit_ma);
    dis = -int'(limits_q.discharge_limit_ma);
    taper = int'(limits_q.full_taper_ma);
    soc_ok = snap.gauge_soc >= {1'b0, limits_q.full_charge_level};
    full_cond = snap.charger_active && soc_ok && (cur < taper);

    case (mode_q)
      STATE_UNKNOWN: begin
        if (cur >= chg) mode_q = STATE_CHARGING;
        else if (cur <= dis) mode_q = STATE_DISCHARGING;
        else if (snap.charger_active && soc_ok) mode_q = STATE_FULL;
        else mode_q = STATE_DISCHARGING;
      end
      STATE_ABSENT: mode_q = STATE_UNKNOWN;
      STATE_DISCHARGING, STATE_CHARGING: begin
        if (mode_q == STATE_DISCHARGING && cur >= chg) begin
          mode_q = STATE_CHARGING;
          settle_pending_q = 1'b0;
        end else if (mode_q == STATE_CHARGING && cur <= dis) begin
          mode_q = STATE_DISCHARGING;
          settle_pending_q = 1'b0;
        end else if (full_cond) begin
          mode_q = STATE_FULL;
          settle_pending_q = 1'b1;
          settle_start_q = snap.time_now_ms;
        end
      end
      STATE_FULL: begin
        if (full_cond) begin
          if (settle_pending_q) begin
            // a clock that went backwards counts as no time at all
            elapsed = (snap.time_now_ms >= settle_start_q) ?
                      snap.time_now_ms - settle_start_q : 32'd0;
            if (elapsed >= limits_q.full_settle_ms) settle_pending_q = 1'b0;
          end
        end else begin
          mode_q = (cur >= chg) ? STATE_CHARGING : STATE_DISCHARGING;
          settle_pending_q = 1'b0;
        end
      end
      default: mode_q = STATE_UNKNOWN;
    endcase

    rep.battery_state = mode_q;
    if (mode_q == STATE_DISCHARGING && snap.validity_bits[VB_EMPTY])
      rep.reported_empty_time_s = snap.gauge_empty_time_s;
    if (mode_q == STATE_CHARGING && snap.validity_bits[VB_FULLT])
      rep.reported_full_time_s = snap.gauge_full_time_s;
    rep.full_settled = (mode_q == STATE_FULL) && !settle_pending_q;
    return rep;
  endfunction

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    item_t snap;
    res_t  want;
    if (!rst_ni) begin
      limits_q.charge_limit_ma    = CHARGE_LIMIT_RST;
      limits_q.discharge_limit_ma = DISCHARGE_LIMIT_RST;
      limits_q.full_taper_ma      = FULL_TAPER_RST;
      limits_q.full_charge_level  = FULL_LEVEL_RST;
      limits_q.full_settle_ms     = FULL_SETTLE_RST;
      mode_q = STATE_UNKNOWN;
      settle_pending_q = 1'b0;
      settle_start_q = '0;
      pending_reports.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_reports.size() == 0) begin
          $display("%0t unexpected report: expected none actual state %h",
                   $time, res.battery_state);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("battery_state", want.battery_state, res.battery_state);
          compare_field("is_present", want.is_present, res.is_present);
          compare_field("report_trusted", want.report_trusted, res.report_trusted);
          compare_field("reported_soc", want.reported_soc, res.reported_soc);
          compare_field("reported_voltage_mv", want.reported_voltage_mv,
                        res.reported_voltage_mv);
          compare_field("reported_current_ma", want.reported_current_ma,
                        res.reported_current_ma);
          compare_field("reported_health", want.reported_health, res.reported_health);
          compare_field("reported_cycles", want.reported_cycles, res.reported_cycles);
          compare_field("reported_empty_time_s", want.reported_empty_time_s,
                        res.reported_empty_time_s);
          compare_field("reported_full_time_s", want.reported_full_time_s,
                        res.reported_full_time_s);
          compare_field("full_settled", want.full_settled, res.full_settled);
        end
      end
      if (req.valid && req.ready) begin
        snap.battery_inserted   = req.battery_inserted;
        snap.charger_active     = req.charger_active;
        snap.validity_bits      = req.validity_bits;
        snap.gauge_soc          = req.gauge_soc;
        snap.gauge_voltage_mv   = req.gauge_voltage_mv;
        snap.gauge_current_ma   = req.gauge_current_ma;
        snap.gauge_health       = req.gauge_health;
        snap.gauge_cycles       = req.gauge_cycles;
        snap.gauge_empty_time_s = req.gauge_empty_time_s;
        snap.gauge_full_time_s  = req.gauge_full_time_s;
        snap.time_now_ms        = req.time_now_ms;
        pending_reports.push_back(track_battery(snap));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDX_CHARGE_LIMIT:    limits_q.charge_limit_ma = cfg_wdata_i[14:0];
          CFG_IDX_DISCHARGE_LIMIT: limits_q.discharge_limit_ma = cfg_wdata_i[14:0];
          CFG_IDX_FULL_TAPER:      limits_q.full_taper_ma = cfg_wdata_i[14:0];
          CFG_IDX_FULL_LEVEL:      limits_q.full_charge_level = cfg_wdata_i[6:0];
          CFG_IDX_FULL_SETTLE:     limits_q.full_settle_ms = cfg_wdata_i;
          default: ;
        endcase
      end
      outstanding = pending_reports.size();
    end
  end

endmodule

FILE: verif/battery_charge_state_tracker_tb.sv
// testbench top for the battery charge state tracker: stimulus, idling and verdict
module battery_charge_state_tracker_tb;
  import bcst_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE = 3'd7;
  localparam logic [6:0] VB_ALL     = 7'h7F;
  localparam logic [6:0] VB_TRUSTED = (7'd1 << VB_SOC) | (7'd1 << VB_VOLT);
  localparam logic [6:0] VB_NO_CURR = VB_ALL & ~(7'd1 << VB_CURR);
  localparam int ITEMS_PER_PHASE = 250;
  localparam int LIMIT_CYCLES    = 400000;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  int                  fail_count;
  int                  outstanding;
  int                  sender_gap_pct;
  int                  receiver_stall_pct;
  logic [31:0]         tnow;
  int                  lim_chg;
  int                  lim_dis;
  int                  lim_taper;
  int                  lim_level;
  logic [31:0]         lim_settle;

  bcst_req_if req ();
  bcst_res_if res ();

  battery_charge_state_tracker uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .res_o       (res)
  );

  battery_charge_state_tracker_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req           (req),
    .res           (res),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    res.ready <= rst_ni && ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  function automatic item_t telemetry(logic present, logic charger, logic [6:0] vb,
                                      logic [7:0] soc, int cur, logic [31:0] stamp);
    item_t s;
    s.battery_inserted   = present;
    s.charger_active     = charger;
    s.validity_bits      = vb;
    s.gauge_soc          = soc;
    s.gauge_voltage_mv   = 16'($urandom);
    s.gauge_current_ma   = cur[15:0];
    s.gauge_health       = 8'($urandom);
    s.gauge_cycles       = 16'($urandom);
    s.gauge_empty_time_s = $urandom;
    s.gauge_full_time_s  = $urandom;
    s.time_now_ms        = stamp;
    return s;
  endfunction

  // mostly well-formed snapshots around the limits, with some noise mixed in
  function automatic item_t random_snapshot();
    item_t       s;
    int          pick;
    int          cur;
    int          soc;
    int unsigned span;
    int          roll;
    pick = $urandom_range(0, 99);
    s = telemetry(1'b1, $urandom_range(0, 9) < 7, 7'($urandom) | VB_TRUSTED,
                  8'($urandom), int'($urandom), 32'($urandom));
    if (pick < 6) begin
      s.battery_inserted = $urandom_range(0, 1);
      s.validity_bits    = 7'($urandom);
      return s;
    end
    roll = $urandom_range(0, 99);
    span = (lim_settle < 32'd200000) ? lim_settle / 3 + 1 : 50000;
    if (roll < 5) tnow = tnow - $urandom_range(1, 5000);
    else if (roll < 8) tnow = $urandom;
    else tnow = tnow + $urandom_range(0, span);
    s.time_now_ms = tnow;
    if (pick < 10) begin
      s.battery_inserted = 1'b0;
      return s;
    end
    if (pick < 15) begin
      s.validity_bits = 7'($urandom);
      s.validity_bits[$urandom_range(VB_SOC, VB_VOLT)] = 1'b0;
      return s;
    end
    if ($urandom_range(0, 9) != 0) s.validity_bits[VB_CURR] = 1'b1;
    if ($urandom_range(0, 1) == 0) begin
      soc = lim_level + $urandom_range(0, 4) - 2;
      if (soc < 0) soc = 0;
      if (soc > 255) soc = 255;
      s.gauge_soc = soc[7:0];
    end
    case ($urandom_range(0, 11))
      0: cur = lim_chg - 1;
      1: cur = lim_chg;
      2: cur = lim_chg + 1;
      3: cur = -lim_dis;
      4: cur = -lim_dis + 1;
      5: cur = -lim_dis - 1;
      6: cur = lim_taper - 1;
      7: cur = lim_taper;
      8: cur = 0;
      9, 10: cur = $urandom_range(0, 1000) - 500;
      default: cur = $urandom_range(0, 65535) - 32768;
    endcase
    if (cur > 32767) cur = 32767;
    if (cur < -32768) cur = -32768;
    s.gauge_current_ma = cur[15:0];
    return s;
  endfunction

  task automatic send_snapshot(item_t s);
    if ($urandom_range(0, 99) < sender_gap_pct) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < sender_gap_pct);
    end
    req.valid              <= 1'b1;
    req.battery_inserted   <= s.battery_inserted;
    req.charger_active     <= s.charger_active;
    req.validity_bits      <= s.validity_bits;
    req.gauge_soc          <= s.gauge_soc;
    req.gauge_voltage_mv   <= s.gauge_voltage_mv;
    req.gauge_current_ma   <= s.gauge_current_ma;
    req.gauge_health       <= s.gauge_health;
    req.gauge_cycles       <= s.gauge_cycles;
    req.gauge_empty_time_s <= s.gauge_empty_time_s;
    req.gauge_full_time_s  <= s.gauge_full_time_s;
    req.time_now_ms        <= s.time_now_ms;
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_limits(logic [31:0] chg_w, logic [31:0] dis_w, logic [31:0] taper_w,
                              logic [31:0] level_w, logic [31:0] settle_w);
    write_reg(CFG_IDX_CHARGE_LIMIT, chg_w);
    write_reg(CFG_IDX_DISCHARGE_LIMIT, dis_w);
    write_reg(CFG_IDX_FULL_TAPER, taper_w);
    write_reg(CFG_IDX_FULL_LEVEL, level_w);
    write_reg(CFG_IDX_FULL_SETTLE, settle_w);
    // writes to an index past the register list must leave everything alone
    write_reg(CFG_IDX_SPARE, $urandom);
    cfg_we_i <= 1'b0;
    lim_chg    = int'(chg_w[14:0]);
    lim_dis    = int'(dis_w[14:0]);
    lim_taper  = int'(taper_w[14:0]);
    lim_level  = int'(level_w[6:0]);
    lim_settle = settle_w;
  endtask

  // hold the sender until every request has its report
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    item_t s;
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= '0;
    cfg_wdata_i            <= '0;
    req.valid              <= 1'b0;
    req.battery_inserted   <= 1'b0;
    req.charger_active     <= 1'b0;
    req.validity_bits      <= '0;
    req.gauge_soc          <= '0;
    req.gauge_voltage_mv   <= '0;
    req.gauge_current_ma   <= '0;
    req.gauge_health       <= '0;
    req.gauge_cycles       <= '0;
    req.gauge_empty_time_s <= '0;
    req.gauge_full_time_s  <= '0;
    req.time_now_ms        <= '0;
    sender_gap_pct     = 18;
    receiver_stall_pct = 80;
    tnow       = '0;
    lim_chg    = int'(CHARGE_LIMIT_RST);
    lim_dis    = int'(DISCHARGE_LIMIT_RST);
    lim_taper  = int'(FULL_TAPER_RST);
    lim_level  = int'(FULL_LEVEL_RST);
    lim_settle = FULL_SETTLE_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk through the modes with the reset limits
    s = telemetry(1'b0, 1'b1, VB_ALL, 8'hFF, 32767, 32'hFFFF_FFFF);
    s.gauge_voltage_mv = '1;
    s.gauge_health = '1;
    s.gauge_cycles = '1;
    s.gauge_empty_time_s = '1;
    s.gauge_full_time_s = '1;
    send_snapshot(s);
    s = telemetry(1'b1, 1'b0, VB_ALL, 8'h00, 0, 32'd0);
    s.gauge_voltage_mv = '0;
    s.gauge_health = '0;
    s.gauge_cycles = '0;
    s.gauge_empty_time_s = '0;
    s.gauge_full_time_s = '0;
    send_snapshot(s);
    send_snapshot(telemetry(1'b1, 1'b1, 7'd1 << VB_SOC, 8'd50, 0, 32'd10));
    s = telemetry(1'b1, 1'b1, VB_ALL, 8'hFF, 50, 32'd100);
    s.gauge_voltage_mv = '1;
    s.gauge_health = '1;
    s.gauge_cycles = '1;
    s.gauge_empty_time_s = '1;
    s.gauge_full_time_s = '1;
    send_snapshot(s);
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd40, -49, 32'd200));
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd40, -32768, 32'd300));
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd40, 49, 32'd400));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd95, 99, 32'd1000));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd95, 99, 32'd30999));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd95, 99, 32'd500));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd95, 99, 32'd31000));
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd95, 10, 32'd31100));
    send_snapshot(telemetry(1'b1, 1'b1, 7'd1 << VB_VOLT, 8'd95, 0, 32'd31200));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd100, 0, 32'd31300));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd100, 100, 32'd31400));
    send_snapshot(telemetry(1'b1, 1'b1, VB_NO_CURR, 8'd99, -32768, 32'd5000));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd99, -50, 32'd6000));
    send_snapshot(telemetry(1'b0, 1'b1, VB_ALL, 8'd99, 0, 32'd7000));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd99, 0, 32'd8000));
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd10, -50, 32'd9000));
    send_snapshot(telemetry(1'b1, 1'b0, 7'd0, 8'd10, 0, 32'd9100));
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd10, 0, 32'd9200));
    send_snapshot(telemetry(1'b1, 1'b1, VB_TRUSTED, 8'd10, 0, 32'd9300));
    send_snapshot(telemetry(1'b1, 1'b1, VB_ALL, 8'd94, 49, 32'd9400));
    send_snapshot(telemetry(1'b1, 1'b0, VB_ALL, 8'd94, 32767, 32'd9500));

    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      case (phase)
        0: apply_limits(32'hABCD_0032, 32'h8000_0032, 32'hFFFF_0064, 32'h0000_FF5F,
                        32'd30000);
        1: apply_limits(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        2: apply_limits(32'd32767, 32'd32767, 32'd32767, 32'd127, 32'hFFFF_FFFF);
        3: apply_limits(32'd200, 32'd300, 32'd150, 32'd80, 32'd1000);
        4: apply_limits(32'd1, 32'd1, 32'd32767, 32'd100, 32'd50);
        5: apply_limits(32'd32767, 32'd0, 32'd5, 32'd101, 32'd0);
        6: apply_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 127),
                        $urandom_range(0, 5000));
        default: apply_limits(32'd50, 32'd50, 32'd100, 32'd95, 32'd30000);
      endcase
      if (phase < 3) begin
        sender_gap_pct = 18;
        receiver_stall_pct = 80;
      end else if (phase < 6) begin
        sender_gap_pct = 80;
        receiver_stall_pct = 18;
      end else begin
        sender_gap_pct = 0;
        receiver_stall_pct = 0;
      end
      // run the timestamp across the 32 bit wrap
      if (phase == 4) tnow = 32'hFFFF_C000;
      repeat (ITEMS_PER_PHASE) send_snapshot(random_snapshot());
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
